### rtl/core/blrrc_pkg.sv
// ----------------------------------------------------------------------------
// blrrc_pkg
// Shared types and constants of the buffer-level rate-ratio controller.
// ----------------------------------------------------------------------------
package blrrc_pkg;

  localparam int FILL_W     = 16;
  localparam int FRAMES_W   = 14;
  localparam int OFFSET_W   = 17;
  localparam int NEED_W     = 17;
  localparam int RATIO_W    = 32;
  localparam int GAIN_W     = 32;
  localparam int TARGET_W   = 16;
  localparam int CFG_DATA_W = 32;
  localparam int QUO_W      = 34;

  // Register stages from the input register to the output register.
  localparam int PIPE_STAGES = 7;

  localparam logic [TARGET_W-1:0] TARGET_RESET      = 16'd4096;
  localparam logic [GAIN_W-1:0]   GAIN_RESET        = 32'd1099;
  localparam logic [RATIO_W-1:0]  ONE_Q30           = 32'h4000_0000;
  localparam logic [NEED_W-1:0]   SAMPLES_PER_FRAME = 17'd6;

  typedef enum logic {
    CFG_TARGET = 1'b0,
    CFG_GAIN   = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    ACT_PRODUCE = 1'b0,
    ACT_CONSUME = 1'b1
  } action_t;

  // Per-item status carried down the ratio pipeline.
  typedef struct packed {
    logic              produce;
    logic              accepted;
    logic [FILL_W-1:0] fill;
  } item_t;

  // Stage load enables issued by the top-level flow control.
  typedef struct packed {
    logic mv_state;
    logic ld_mul;
    logic ld_off;
    logic ld_pp;
    logic ld_quo;
  } pipe_ctl_t;

endpackage

### rtl/core/blrrc_ram.sv
// ----------------------------------------------------------------------------
// blrrc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module blrrc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/blrrc_state.sv
// ----------------------------------------------------------------------------
// blrrc_state
// Fill tracking, offset clamp and history ring with its running sum.
// ----------------------------------------------------------------------------
module blrrc_state #(
  parameter int RING_SAMPLES  = 65536,
  parameter int HISTORY_DEPTH = 32,
  parameter int CHUNK_SAMPLES = 256
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  blrrc_pkg::pipe_ctl_t                                   ctl,
  input  logic                                                   action,
  input  logic [blrrc_pkg::FRAMES_W-1:0]                         frames,
  input  logic [blrrc_pkg::TARGET_W-1:0]                         target,
  output blrrc_pkg::item_t                                       item,
  output logic signed [blrrc_pkg::OFFSET_W+$clog2(HISTORY_DEPTH)-1:0] sum
);

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int SUM_W = blrrc_pkg::OFFSET_W + PTR_W;
  localparam int FW    = blrrc_pkg::FILL_W;
  localparam int OW    = blrrc_pkg::OFFSET_W;
  localparam int NW    = blrrc_pkg::NEED_W;

  localparam logic [FW-1:0] CAPACITY   = FW'(RING_SAMPLES - 1);
  localparam logic [FW-1:0] FILL_RESET =
      (blrrc_pkg::TARGET_RESET > CAPACITY) ? CAPACITY : blrrc_pkg::TARGET_RESET;
  localparam logic [FW-1:0] CHUNK      = FW'(CHUNK_SAMPLES);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

  logic [FW-1:0]           fill;
  logic [PTR_W-1:0]        ptr;
  logic                    wrapped;
  logic                    produce;
  logic                    accepted;

  logic signed [OW-1:0]    offset_raw;
  logic signed [OW-1:0]    bound;
  logic signed [OW-1:0]    offset;
  logic signed [OW-1:0]    old_entry;
  logic [OW-1:0]           rd_data;
  logic signed [SUM_W-1:0] sum_next;
  logic [FW-1:0]           space;
  logic [NW-1:0]           need;
  logic                    fits;
  logic [PTR_W-1:0]        ptr_inc;
  logic [PTR_W-1:0]        raddr;
  logic                    wr;

  always_comb begin
    offset_raw = $signed({1'b0, target}) - $signed({1'b0, fill});
    bound      = $signed({1'b0, target});
    if (offset_raw < -bound) begin
      offset = -bound;
    end else if (offset_raw > bound) begin
      offset = bound;
    end else begin
      offset = offset_raw;
    end
    // Entries not yet written since reset read as zero.
    old_entry = wrapped ? $signed(rd_data) : '0;
    sum_next  = sum - SUM_W'(old_entry) + SUM_W'(offset);
    space     = (fill <= CAPACITY) ? (CAPACITY - fill) : '0;
    need      = NW'(frames) * blrrc_pkg::SAMPLES_PER_FRAME;
    fits      = (need <= {1'b0, space});
    ptr_inc   = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
    wr        = ctl.mv_state && (action == blrrc_pkg::ACT_PRODUCE);
    raddr     = wr ? ptr_inc : ptr;
  end

  blrrc_ram #(
    .WIDTH (OW),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (wr),
    .waddr (ptr),
    .wdata (offset),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= FILL_RESET;
      ptr     <= '0;
      wrapped <= 1'b0;
      sum     <= '0;
    end else if (ctl.mv_state) begin
      if (action == blrrc_pkg::ACT_PRODUCE) begin
        sum     <= sum_next;
        ptr     <= ptr_inc;
        wrapped <= wrapped | (ptr == PTR_LAST);
        if (fits) begin
          fill <= fill + need[FW-1:0];
        end
      end else if (fill >= CHUNK) begin
        fill <= fill - CHUNK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mv_state) begin
      produce  <= (action == blrrc_pkg::ACT_PRODUCE);
      accepted <= (action == blrrc_pkg::ACT_PRODUCE) ? fits : (fill >= CHUNK);
    end
  end

  assign item.produce  = produce;
  assign item.accepted = accepted;
  assign item.fill     = fill;

endmodule

### rtl/core/blrrc_ratio.sv
// ----------------------------------------------------------------------------
// blrrc_ratio
// Pipelined gain multiply and floor division of the history sum.
// ----------------------------------------------------------------------------
module blrrc_ratio #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                                                   clk,
  input  blrrc_pkg::pipe_ctl_t                                   ctl,
  input  logic [blrrc_pkg::GAIN_W-1:0]                           gain,
  input  blrrc_pkg::item_t                                       item_in,
  input  logic signed [blrrc_pkg::OFFSET_W+$clog2(HISTORY_DEPTH)-1:0] sum_in,
  output blrrc_pkg::item_t                                       item_out,
  output logic [blrrc_pkg::QUO_W-1:0]                            quo
);

  localparam int C      = $clog2(HISTORY_DEPTH);
  localparam int SUM_W  = blrrc_pkg::OFFSET_W + C;
  localparam int PROD_W = blrrc_pkg::GAIN_W + 1 + SUM_W;
  // Offset dividend u = clamp(prod/1024) + (2^30+1)*D stays below 2^U_W.
  localparam int U_W    = blrrc_pkg::GAIN_W + 1 + C;
  localparam int SH     = U_W + C;
  localparam int M_W    = U_W + 2;
  localparam int UL     = U_W / 2;
  localparam int UH     = U_W - UL;
  localparam int ML     = M_W / 2;
  localparam int MH     = M_W - ML;
  localparam int PW     = U_W + M_W;

  localparam logic [63:0] RECIP64 =
      ((64'd1 << SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam logic [M_W-1:0] RECIP = RECIP64[M_W-1:0];

  localparam longint LO_L = -(longint'(blrrc_pkg::ONE_Q30) + 64'sd1)
                            * longint'(HISTORY_DEPTH);
  localparam longint HI_L = 64'sd3 * longint'(blrrc_pkg::ONE_Q30)
                            * longint'(HISTORY_DEPTH);
  localparam logic signed [PROD_W-1:0] T_LO = PROD_W'(LO_L);
  localparam logic signed [PROD_W-1:0] T_HI = PROD_W'(HI_L);

  blrrc_pkg::item_t         item_mul, item_off, item_pp;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] gain_x;
  logic signed [PROD_W-1:0] sum_x;
  logic signed [PROD_W-1:0] t_sh;
  logic signed [PROD_W-1:0] t_cl;
  logic [U_W-1:0]           u;
  logic [UL+ML-1:0]         pp_ll;
  logic [UH+ML-1:0]         pp_hl;
  logic [UL+MH-1:0]         pp_lh;
  logic [UH+MH-1:0]         pp_hh;
  logic [PW-1:0]            full;

  always_comb begin
    gain_x = $signed(PROD_W'({1'b0, gain}));
    sum_x  = PROD_W'(sum_in);
    t_sh   = prod >>> 10;
    // Values beyond these bounds saturate the ratio anyway.
    if (t_sh < T_LO) begin
      t_cl = T_LO;
    end else if (t_sh > T_HI) begin
      t_cl = T_HI;
    end else begin
      t_cl = t_sh;
    end
    full = (PW'(pp_hh) << (UL + ML)) + (PW'(pp_hl) << UL) +
           (PW'(pp_lh) << ML) + PW'(pp_ll);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      prod     <= gain_x * sum_x;
      item_mul <= item_in;
    end
    if (ctl.ld_off) begin
      u        <= U_W'(t_cl - T_LO);
      item_off <= item_mul;
    end
    if (ctl.ld_pp) begin
      pp_ll   <= (UL+ML)'(u[UL-1:0]) * (UL+ML)'(RECIP[ML-1:0]);
      pp_hl   <= (UH+ML)'(u[U_W-1:UL]) * (UH+ML)'(RECIP[ML-1:0]);
      pp_lh   <= (UL+MH)'(u[UL-1:0]) * (UL+MH)'(RECIP[M_W-1:ML]);
      pp_hh   <= (UH+MH)'(u[U_W-1:UL]) * (UH+MH)'(RECIP[M_W-1:ML]);
      item_pp <= item_off;
    end
    if (ctl.ld_quo) begin
      quo      <= full[SH +: blrrc_pkg::QUO_W];
      item_out <= item_pp;
    end
  end

endmodule

### rtl/core/buffer_level_rate_ratio_control.sv
// ----------------------------------------------------------------------------
// buffer_level_rate_ratio_control
// Ring fill tracking and resampling-ratio servo toward a target fill level.
// ----------------------------------------------------------------------------
// Throughput: one item per clock cycle while the output is not stalled;
// every stage has its own valid bit, so the block keeps taking items until
// all seven stage registers are full and the output is stalled.
// Reset (rst, synchronous, active high) empties the pipeline, sets the fill
// to min(4096, RING_SAMPLES-1), clears the offset history, sets the ratio to
// 1.0 and returns target_level and loop_gain to 4096 and 1099.
// ----------------------------------------------------------------------------
module buffer_level_rate_ratio_control #(
  parameter int RING_SAMPLES  = 65536,
  parameter int HISTORY_DEPTH = 32,
  parameter int CHUNK_SAMPLES = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [13:0] frame_count, [15:14] zero
  input  logic        s_tuser,   // [0] action
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] ratio, [47:32] fill_level
  output logic        m_tuser,   // [0] accepted
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NST   = blrrc_pkg::PIPE_STAGES;
  localparam int SUM_W = blrrc_pkg::OFFSET_W + $clog2(HISTORY_DEPTH);
  localparam logic [blrrc_pkg::QUO_W-1:0] QUO_ONE = blrrc_pkg::QUO_W'(1);
  localparam logic [blrrc_pkg::QUO_W-1:0] QUO_MAX = blrrc_pkg::QUO_W'(64'h1_0000_0000);

  // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
  logic [blrrc_pkg::TARGET_W-1:0] target_level;
  logic [blrrc_pkg::GAIN_W-1:0]   loop_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= blrrc_pkg::TARGET_RESET;
      loop_gain    <= blrrc_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      unique case (blrrc_pkg::cfg_idx_t'(cfg_index))
        blrrc_pkg::CFG_TARGET: target_level <= cfg_data[blrrc_pkg::TARGET_W-1:0];
        blrrc_pkg::CFG_GAIN:   loop_gain    <= cfg_data[blrrc_pkg::GAIN_W-1:0];
      endcase
    end
  end

  // Flow control. Stage 0 is the input register, stage 1 the state update,
  // stages 2 to 5 the ratio arithmetic and stage 6 the output register.
  // A stage loads when it is empty or when its content moves on, so a
  // stalled output only backs up as far as the pipeline is full.
  logic [NST-1:0] vld;
  logic [NST-1:0] ld;

  always_comb begin
    ld[NST-1] = !vld[NST-1] || m_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = ld[0];

  blrrc_pkg::pipe_ctl_t ctl;
  assign ctl.mv_state = vld[0] && ld[1];
  assign ctl.ld_mul   = ld[2];
  assign ctl.ld_off   = ld[3];
  assign ctl.ld_pp    = ld[4];
  assign ctl.ld_quo   = ld[5];

  // Input register.
  logic                           in_action;
  logic [blrrc_pkg::FRAMES_W-1:0] in_frames;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      in_action <= s_tuser;
      in_frames <= s_tdata[blrrc_pkg::FRAMES_W-1:0];
    end
  end

  // Fill accounting and the offset history ring.
  blrrc_pkg::item_t        st_item;
  logic signed [SUM_W-1:0] st_sum;

  blrrc_state #(
    .RING_SAMPLES  (RING_SAMPLES),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .CHUNK_SAMPLES (CHUNK_SAMPLES)
  ) u_state (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .action (in_action),
    .frames (in_frames),
    .target (target_level),
    .item   (st_item),
    .sum    (st_sum)
  );

  // Ratio arithmetic: floor(loop_gain * sum / (HISTORY_DEPTH * 1024)),
  // returned offset so that the ratio is quo - 1 before saturation.
  blrrc_pkg::item_t               rq_item;
  logic [blrrc_pkg::QUO_W-1:0]    rq_quo;

  blrrc_ratio #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ratio (
    .clk      (clk),
    .ctl      (ctl),
    .gain     (loop_gain),
    .item_in  (st_item),
    .sum_in   (st_sum),
    .item_out (rq_item),
    .quo      (rq_quo)
  );

  // Output stage. Consume items repeat the ratio of the latest produce item
  // that passed this stage before them, or 1.0 if none has since reset.
  logic [blrrc_pkg::RATIO_W-1:0] last_ratio;
  logic [blrrc_pkg::RATIO_W-1:0] sat_ratio;
  logic [blrrc_pkg::RATIO_W-1:0] ratio_next;
  logic [blrrc_pkg::RATIO_W-1:0] out_ratio;
  logic [blrrc_pkg::FILL_W-1:0]  out_fill;
  logic                          out_acc;

  always_comb begin
    if (rq_quo == '0) begin
      sat_ratio = '0;
    end else if (rq_quo > QUO_MAX) begin
      sat_ratio = '1;
    end else begin
      sat_ratio = blrrc_pkg::RATIO_W'(rq_quo - QUO_ONE);
    end
    ratio_next = rq_item.produce ? sat_ratio : last_ratio;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ratio <= blrrc_pkg::ONE_Q30;
    end else if (vld[NST-2] && ld[NST-1]) begin
      last_ratio <= ratio_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NST-1]) begin
      out_ratio <= ratio_next;
      out_fill  <= rq_item.fill;
      out_acc   <= rq_item.accepted;
    end
  end

  assign m_tvalid = vld[NST-1];
  assign m_tdata  = {out_fill, out_ratio};
  assign m_tuser  = out_acc;

endmodule

### rtl/core/blrrc_checker.sv
// ----------------------------------------------------------------------------
// blrrc_checker
// Port-level checks of the rate-ratio controller, bound to the top level.
// ----------------------------------------------------------------------------
module blrrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // Items accepted but not yet delivered.
  logic [3:0] inflight;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_idle_ready: assert property (@(posedge clk) !m_tvalid |-> s_tready)
    else $error("input stalled while no result is pending");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (inflight != 4'd0) && (inflight <= 4'(blrrc_pkg::PIPE_STAGES)))
    else $error("result count does not match accepted items");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind buffer_level_rate_ratio_control blrrc_checker u_blrrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
